>>> sv/color_space_converter_assert.svh
// assertion macros for the converter rtl
// expects clk and arst_n in the scope of each use
`ifndef COLOR_SPACE_CONVERTER_ASSERT_SVH
`define COLOR_SPACE_CONVERTER_ASSERT_SVH

// combinational or same-cycle implication, checked out of reset
`define CSC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// next-cycle implication
`define CSC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/csc_pkg.sv
// types, codes and divider step for the color space converter
// no dependencies
package csc_pkg;

	localparam int CHANNEL_BITS = 8;
	localparam int HUE_BITS     = 15;

	// commands
	localparam logic [2:0] CMD_RGB2HSV = 3'd0;
	localparam logic [2:0] CMD_HSV2RGB = 3'd1;
	localparam logic [2:0] CMD_SWAP    = 3'd2;
	localparam logic [2:0] CMD_CMY2HSV = 3'd3;
	localparam logic [2:0] CMD_HSV2CMY = 3'd4;

	// which channel holds the maximum
	localparam logic [1:0] MAX_RED   = 2'd0;
	localparam logic [1:0] MAX_GREEN = 2'd1;
	localparam logic [1:0] MAX_BLUE  = 2'd2;

	localparam logic [HUE_BITS-1:0] HUE_SECTOR = 15'd3840;
	localparam logic [HUE_BITS-1:0] HUE_TURN   = 15'd23040;

	typedef logic [CHANNEL_BITS-1:0] chan_t;

	typedef struct packed {
		logic [2:0]          command;
		logic [HUE_BITS-1:0] in_first;
		chan_t               in_second;
		chan_t               in_third;
	} csc_pix_t;

	typedef struct packed {
		logic [HUE_BITS-1:0] out_first;
		chan_t               out_second;
		chan_t               out_third;
		logic                hue_out_of_range;
	} csc_res_t;

	typedef struct packed {
		chan_t      rem;
		logic [3:0] quo;
	} csc_div_t;

	// four restoring division steps, msb first
	function automatic csc_div_t div_step4(input chan_t rem, input logic [3:0] bits,
		input chan_t den);
		logic [CHANNEL_BITS:0] trial;
		csc_div_t res;
		res.rem = rem;
		res.quo = '0;
		for (int i = 3; i >= 0; i--) begin
			trial = {res.rem, bits[i]};
			if (trial >= {1'b0, den}) begin
				res.rem = CHANNEL_BITS'(trial - {1'b0, den});
				res.quo[i] = 1'b1;
			end else begin
				res.rem = trial[CHANNEL_BITS-1:0];
			end
		end
		return res;
	endfunction

endpackage

>>> sv/color_space_converter.sv
// color space converter top level: rgb/hsv/cmy conversion pipeline
// depends on csc_pkg and color_space_converter_assert.svh
//
// Converts one pixel triple per clock between RGB, HSV and CMY according to the
// command carried with each pixel. The datapath is a five-stage pipeline: a pixel
// accepted at one edge comes out as a result four cycles later, and a new pixel
// may be taken every cycle. The two hue and saturation quotients come from
// restoring dividers that resolve four quotient bits per stage (three stages for
// the 12-bit hue quotient, two for the 8-bit saturation); divisions by 255 and
// 3840 use reciprocal multiplies with a one-step correction. When the result
// register is held by the consumer, the whole pipeline holds; no transfer is
// lost or repeated. Hue is in 1/64 degree (0..23039). A gray input gives hue 0,
// an HSV hue of a full turn or more gives a flat gray result and sets the flag,
// and unused commands give an all-zero result.
module color_space_converter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pixel_valid,
	output logic              pixel_ready,
	input  csc_pkg::csc_pix_t pixel,
	output logic              result_valid,
	input  logic              result_ready,
	output csc_pkg::csc_res_t result
);
	import csc_pkg::*;

	// whole pipeline moves when the result register is empty or being taken
	logic adv;
	assign adv         = !result_valid || result_ready;
	assign pixel_ready = adv;

	// ---------------- stage 0 (input, combinational) ----------------
	logic        inv;
	chan_t       a0, a1, a2, hi, lo, dd, pa, pb, mag;
	logic        neg;
	logic [1:0]  hsel;
	logic [15:0] vs;
	logic [3:0]  sec;
	logic [HUE_BITS-1:0] hp, tt;
	logic [11:0] ww;

	assign inv = (pixel.command == CMD_CMY2HSV);
	// 255 - x is the bitwise complement
	assign a0 = pixel.in_first[CHANNEL_BITS-1:0] ^ {CHANNEL_BITS{inv}};
	assign a1 = pixel.in_second ^ {CHANNEL_BITS{inv}};
	assign a2 = pixel.in_third ^ {CHANNEL_BITS{inv}};

	always_comb begin
		hi = a0;
		lo = a0;
		if (a1 > hi) hi = a1;
		if (a2 > hi) hi = a2;
		if (a1 < lo) lo = a1;
		if (a2 < lo) lo = a2;
		// red wins ties over green, green over blue
		if (hi == a0) begin
			hsel = MAX_RED;
			pa = a1;
			pb = a2;
		end else if (hi == a1) begin
			hsel = MAX_GREEN;
			pa = a2;
			pb = a0;
		end else begin
			hsel = MAX_BLUE;
			pa = a0;
			pb = a1;
		end
		dd  = hi - lo;
		neg = pa < pb;
		mag = neg ? (pb - pa) : (pa - pb);
	end

	// hsv side: chroma product, sector and triangle weight
	assign vs = 16'(pixel.in_second) * 16'(pixel.in_third);

	always_comb begin
		sec = '0;
		for (int k = 1; k <= 8; k++) begin
			if (pixel.in_first >= HUE_BITS'(k * 3840)) sec = 4'(k);
		end
		hp = pixel.in_first - HUE_BITS'(HUE_BITS'(sec[3:1]) * HUE_BITS'(7680));
		tt = (hp >= HUE_SECTOR) ? (hp - HUE_SECTOR) : (HUE_SECTOR - hp);
		ww = 12'(HUE_SECTOR - tt);
	end

	// ---------------- stage 1 ----------------
	logic        vld_s1;
	logic [2:0]  cmd_s1;
	chan_t       hi_s1, d_s1, mag_s1, v_s1, r_s1, g_s1, b_s1;
	logic        neg_s1;
	logic [1:0]  hsel_s1;
	logic [15:0] vs_s1;
	logic [11:0] w_s1;
	logic [3:0]  sec_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= pixel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1  <= pixel.command;
			hi_s1   <= hi;
			d_s1    <= dd;
			mag_s1  <= mag;
			neg_s1  <= neg;
			hsel_s1 <= hsel;
			vs_s1   <= vs;
			w_s1    <= ww;
			sec_s1  <= sec;
			v_s1    <= pixel.in_third;
			r_s1    <= pixel.in_first[CHANNEL_BITS-1:0];
			g_s1    <= pixel.in_second;
			b_s1    <= pixel.in_third;
		end
	end

	// ---------------- stage 2: first divider steps, chroma /255 ----------------
	logic [19:0] hnum;
	logic [15:0] snum;
	csc_div_t    hdiv2, sdiv2;
	logic [23:0] cprod;
	chan_t       c0;
	logic [15:0] crem;
	chan_t       cc;

	assign hnum  = (20'(mag_s1) << 12) - (20'(mag_s1) << 8);
	assign snum  = (16'(d_s1) << 8) - 16'(d_s1);
	assign hdiv2 = div_step4(hnum[19:12], hnum[11:8], d_s1);
	assign sdiv2 = div_step4(snum[15:8], snum[7:4], hi_s1);

	always_comb begin
		cprod = 24'(vs_s1) + (24'(vs_s1) << 8);
		c0    = cprod[23:16];
		crem  = vs_s1 - 16'(c0) * 16'd255;
		cc    = (crem >= 16'd255) ? (c0 + 1'b1) : c0;
	end

	logic        vld_s2;
	logic [2:0]  cmd_s2;
	chan_t       hi_s2, d_s2, v_s2, r_s2, g_s2, b_s2, c_s2, hrem_s2, srem_s2;
	logic        neg_s2;
	logic [1:0]  hsel_s2;
	logic [11:0] w_s2;
	logic [3:0]  sec_s2, hq_s2, sq_s2, slow_s2;
	logic [7:0]  hlow_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s2  <= cmd_s1;
			hi_s2   <= hi_s1;
			d_s2    <= d_s1;
			neg_s2  <= neg_s1;
			hsel_s2 <= hsel_s1;
			w_s2    <= w_s1;
			sec_s2  <= sec_s1;
			v_s2    <= v_s1;
			r_s2    <= r_s1;
			g_s2    <= g_s1;
			b_s2    <= b_s1;
			c_s2    <= cc;
			hrem_s2 <= hdiv2.rem;
			hq_s2   <= hdiv2.quo;
			hlow_s2 <= hnum[7:0];
			srem_s2 <= sdiv2.rem;
			sq_s2   <= sdiv2.quo;
			slow_s2 <= snum[3:0];
		end
	end

	// ---------------- stage 3: divider steps, x product ----------------
	csc_div_t    hdiv3, sdiv3;
	logic [19:0] xp;

	assign hdiv3 = div_step4(hrem_s2, hlow_s2[7:4], d_s2);
	assign sdiv3 = div_step4(srem_s2, slow_s2, hi_s2);
	assign xp    = 20'(c_s2) * 20'(w_s2);

	logic        vld_s3;
	logic [2:0]  cmd_s3;
	chan_t       hi_s3, d_s3, v_s3, r_s3, g_s3, b_s3, c_s3, hrem_s3, sat_s3;
	logic        neg_s3;
	logic [1:0]  hsel_s3;
	logic [3:0]  sec_s3, hlow_s3;
	logic [7:0]  hq_s3;
	logic [19:0] xp_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s3  <= cmd_s2;
			hi_s3   <= hi_s2;
			d_s3    <= d_s2;
			neg_s3  <= neg_s2;
			hsel_s3 <= hsel_s2;
			sec_s3  <= sec_s2;
			v_s3    <= v_s2;
			r_s3    <= r_s2;
			g_s3    <= g_s2;
			b_s3    <= b_s2;
			c_s3    <= c_s2;
			hrem_s3 <= hdiv3.rem;
			hq_s3   <= {hq_s2, hdiv3.quo};
			hlow_s3 <= hlow_s2[3:0];
			sat_s3  <= {sq_s2, sdiv3.quo};
			xp_s3   <= xp;
		end
	end

	// ---------------- stage 4: last hue step, x / 3840 ----------------
	csc_div_t    hdiv4;
	logic [11:0] xn;
	logic [23:0] xprod;

	assign hdiv4 = div_step4(hrem_s3, hlow_s3, d_s3);
	// x / 3840 = (x >> 8) / 15, reciprocal estimate here
	assign xn    = xp_s3[19:8];
	assign xprod = 24'(xn) * 24'd4369;

	logic        vld_s4;
	logic [2:0]  cmd_s4;
	chan_t       hi_s4, v_s4, r_s4, g_s4, b_s4, c_s4, sat_s4, x0_s4;
	logic        gray_s4, neg_s4;
	logic [1:0]  hsel_s4;
	logic [3:0]  sec_s4;
	logic [11:0] hq_s4, xn_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s4  <= cmd_s3;
			hi_s4   <= hi_s3;
			gray_s4 <= (d_s3 == '0);
			neg_s4  <= neg_s3;
			hsel_s4 <= hsel_s3;
			sec_s4  <= sec_s3;
			v_s4    <= v_s3;
			r_s4    <= r_s3;
			g_s4    <= g_s3;
			b_s4    <= b_s3;
			c_s4    <= c_s3;
			sat_s4  <= sat_s3;
			hq_s4   <= {hq_s3, hdiv4.quo};
			xn_s4   <= xn;
			x0_s4   <= xprod[23:16];
		end
	end

	// ---------------- stage 5: finish and select ----------------
	logic [11:0]         xrem;
	chan_t               xx, mm, rr, gg, bb, cr, cg, cb;
	logic                flag;
	logic [HUE_BITS-1:0] hue, hq15;
	chan_t               sat;
	csc_res_t            res_d;

	always_comb begin
		// reciprocal can land one low
		xrem = xn_s4 - 12'(x0_s4) * 12'd15;
		xx   = (xrem >= 12'd15) ? (x0_s4 + 1'b1) : x0_s4;
		mm   = v_s4 - c_s4;
		cr   = '0;
		cg   = '0;
		cb   = '0;
		flag = 1'b0;
		case (sec_s4)
			4'd0: begin cr = c_s4; cg = xx; end
			4'd1: begin cr = xx; cg = c_s4; end
			4'd2: begin cg = c_s4; cb = xx; end
			4'd3: begin cg = xx; cb = c_s4; end
			4'd4: begin cr = xx; cb = c_s4; end
			4'd5: begin cr = c_s4; cb = xx; end
			default: flag = 1'b1; // hue of a full turn or more
		endcase
		rr = cr + mm;
		gg = cg + mm;
		bb = cb + mm;
	end

	always_comb begin
		hq15 = HUE_BITS'(hq_s4);
		case (hsel_s4)
			MAX_RED:   hue = (neg_s4 && hq15 != '0) ? (HUE_TURN - hq15) : hq15;
			MAX_GREEN: hue = neg_s4 ? (HUE_BITS'(7680) - hq15) : (HUE_BITS'(7680) + hq15);
			default:   hue = neg_s4 ? (HUE_BITS'(15360) - hq15) : (HUE_BITS'(15360) + hq15);
		endcase
		if (gray_s4) hue = '0;
		sat = (hi_s4 == '0) ? '0 : sat_s4;
	end

	always_comb begin
		res_d = '0;
		unique case (cmd_s4) inside
			CMD_RGB2HSV, CMD_CMY2HSV: begin
				res_d.out_first  = hue;
				res_d.out_second = sat;
				res_d.out_third  = hi_s4;
			end
			CMD_HSV2RGB: begin
				res_d.out_first        = HUE_BITS'(rr);
				res_d.out_second       = gg;
				res_d.out_third        = bb;
				res_d.hue_out_of_range = flag;
			end
			CMD_SWAP: begin
				// complement at channel width, then zero-extend
				res_d.out_first  = {{(HUE_BITS-CHANNEL_BITS){1'b0}}, ~r_s4};
				res_d.out_second = ~g_s4;
				res_d.out_third  = ~b_s4;
			end
			CMD_HSV2CMY: begin
				res_d.out_first        = {{(HUE_BITS-CHANNEL_BITS){1'b0}}, ~rr};
				res_d.out_second       = ~gg;
				res_d.out_third        = ~bb;
				res_d.hue_out_of_range = flag;
			end
			default: res_d = '0; // unused commands
		endcase
	end

	// result register
	logic [2:0] cmd_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv) begin
			result_valid <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result <= res_d;
			cmd_s5 <= cmd_s4;
		end
	end

	// ---------------- checks ----------------
`include "color_space_converter_assert.svh"

	`CSC_ASSERT_NEXT(a_valid_moves, vld_s2 && adv, vld_s3, "valid lost between stages")
	`CSC_ASSERT(a_hue_range,
		!result_valid || cmd_s5 == CMD_SWAP || result.out_first < HUE_TURN, "hue out of range")
	`CSC_ASSERT(a_unused_zero,
		!(result_valid && cmd_s5 > CMD_HSV2CMY) || result == '0, "unused command not zero")
	`CSC_ASSERT(a_flag_cmd,
		!(result_valid && result.hue_out_of_range) || cmd_s5 == CMD_HSV2RGB
		|| cmd_s5 == CMD_HSV2CMY, "flag on non-hsv input")

endmodule

>>> dv/testbench.sv
// self-checking testbench for color_space_converter
// depends on csc_pkg and the converter rtl
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import csc_pkg::*;

	localparam int CMAXI = 255;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pixel_valid = 1'b0;
	logic pixel_ready;
	csc_pix_t pixel = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	csc_res_t result;

	csc_pix_t pending_pixels[$];
	csc_res_t expected_results[$];
	int errors = 0;
	int idle_cycles = 0;
	int in_gap = 0;
	int out_gap = 0;

	always #10 clk = ~clk;

	color_space_converter uut (
		.clk(clk), .arst_n(arst_n),
		.pixel_valid(pixel_valid), .pixel_ready(pixel_ready), .pixel(pixel),
		.result_valid(result_valid), .result_ready(result_ready), .result(result)
	);

	// hue, saturation, value of one rgb triple
	function automatic csc_res_t hsv_of(int r, int g, int b);
		csc_res_t o;
		int hi, lo, d, hue;
		hi = r; lo = r; hue = 0;
		if (g > hi) hi = g;
		if (b > hi) hi = b;
		if (g < lo) lo = g;
		if (b < lo) lo = b;
		d = hi - lo;
		// gray pixels keep hue at zero
		if (d != 0) begin
			if (hi == r) begin
				hue = (3840 * (g - b)) / d;
				if (hue < 0) hue += 23040;
			end else if (hi == g) begin
				hue = (3840 * (b - r)) / d + 7680;
			end else begin
				hue = (3840 * (r - g)) / d + 15360;
			end
		end
		o = '0;
		o.out_first = hue[14:0];
		o.out_second = (hi == 0) ? 8'd0 : 8'((d * CMAXI) / hi);
		o.out_third = 8'(hi);
		return o;
	endfunction

	// rgb of one hsv triple, flag set for a hue of a full turn or more
	function automatic csc_res_t rgb_of(int h, int s, int v);
		csc_res_t o;
		int c, m, x, t, hp, r, g, b;
		c = (v * s) / CMAXI;
		m = v - c;
		hp = h % 7680;
		t = (hp >= 3840) ? hp - 3840 : 3840 - hp;
		x = (c * (3840 - t)) / 3840;
		r = 0; g = 0; b = 0;
		o = '0;
		case (h / 3840)
			0: begin r = c; g = x; end
			1: begin r = x; g = c; end
			2: begin g = c; b = x; end
			3: begin g = x; b = c; end
			4: begin r = x; b = c; end
			5: begin r = c; b = x; end
			default: o.hue_out_of_range = 1'b1;
		endcase
		o.out_first = 15'(r + m);
		o.out_second = 8'(g + m);
		o.out_third = 8'(b + m);
		return o;
	endfunction

	function automatic csc_res_t convert_pixel(csc_pix_t p);
		csc_res_t o;
		int c0, c1, c2;
		c0 = p.in_first[7:0];
		c1 = p.in_second;
		c2 = p.in_third;
		o = '0;
		case (p.command)
			CMD_RGB2HSV: o = hsv_of(c0, c1, c2);
			CMD_HSV2RGB: o = rgb_of(p.in_first, c1, c2);
			CMD_SWAP: begin
				o.out_first = 15'(CMAXI - c0);
				o.out_second = 8'(CMAXI - c1);
				o.out_third = 8'(CMAXI - c2);
			end
			CMD_CMY2HSV: o = hsv_of(CMAXI - c0, CMAXI - c1, CMAXI - c2);
			CMD_HSV2CMY: begin
				o = rgb_of(p.in_first, c1, c2);
				o.out_first = 15'(CMAXI - o.out_first);
				o.out_second = 8'(CMAXI - o.out_second);
				o.out_third = 8'(CMAXI - o.out_third);
			end
			default: o = '0;
		endcase
		return o;
	endfunction

	function automatic int gap_len();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 55) return 0;
		if (sel < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic queue_pixel(logic [2:0] cmd, logic [14:0] f, logic [7:0] s, logic [7:0] t);
		csc_pix_t p;
		p.command = cmd;
		p.in_first = f;
		p.in_second = s;
		p.in_third = t;
		pending_pixels.insert(pending_pixels.size(), p);
	endtask

	// driver: holds valid and payload until the transfer completes
	always @(posedge clk) begin
		if (arst_n) begin
			if (pixel_valid && pixel_ready) begin
				expected_results.insert(expected_results.size(), convert_pixel(pixel));
			end
			if (!pixel_valid || pixel_ready) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					pixel_valid <= 1'b0;
				end else if (pending_pixels.size() > 0) begin
					pixel <= pending_pixels.pop_front();
					pixel_valid <= 1'b1;
					in_gap <= gap_len();
				end else begin
					pixel_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compares each result transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t unexpected result %h", $time, result);
					errors++;
				end else begin
					csc_res_t e;
					e = expected_results.pop_front();
					if (e.out_first !== result.out_first)
						$display("%0t out_first exp %0d act %0d", $time, e.out_first,
							result.out_first);
					if (e.out_second !== result.out_second)
						$display("%0t out_second exp %0d act %0d", $time, e.out_second,
							result.out_second);
					if (e.out_third !== result.out_third)
						$display("%0t out_third exp %0d act %0d", $time, e.out_third,
							result.out_third);
					if (e.hue_out_of_range !== result.hue_out_of_range)
						$display("%0t hue_out_of_range exp %0b act %0b", $time,
							e.hue_out_of_range, result.hue_out_of_range);
					if (e !== result) errors++;
				end
			end
			// random backpressure on the result side
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
				out_gap <= gap_len();
			end
			if ((pixel_valid && pixel_ready) || (result_valid && result_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		int sel;
		// directed: extremes, every command, gray, hue wrap, wide channel, unused codes
		queue_pixel(CMD_RGB2HSV, 15'd0, 8'd0, 8'd0);
		queue_pixel(CMD_RGB2HSV, 15'd255, 8'd255, 8'd255);
		queue_pixel(CMD_RGB2HSV, 15'd255, 8'd0, 8'd0);
		queue_pixel(CMD_RGB2HSV, 15'd255, 8'd0, 8'd10);
		queue_pixel(CMD_RGB2HSV, 15'd255, 8'd255, 8'd0);
		queue_pixel(CMD_RGB2HSV, 15'd0, 8'd255, 8'd255);
		queue_pixel(CMD_RGB2HSV, 15'd10, 8'd0, 8'd255);
		queue_pixel(CMD_RGB2HSV, 15'h7f80, 8'd3, 8'd7);
		queue_pixel(CMD_HSV2RGB, 15'd0, 8'd255, 8'd255);
		queue_pixel(CMD_HSV2RGB, 15'd23039, 8'd255, 8'd255);
		queue_pixel(CMD_HSV2RGB, 15'd23040, 8'd128, 8'd200);
		queue_pixel(CMD_HSV2RGB, 15'h7fff, 8'd255, 8'd255);
		queue_pixel(CMD_HSV2RGB, 15'd3840, 8'd0, 8'd0);
		queue_pixel(CMD_SWAP, 15'd0, 8'd255, 8'd0);
		queue_pixel(CMD_SWAP, 15'h7fff, 8'd0, 8'd255);
		queue_pixel(CMD_CMY2HSV, 15'd0, 8'd0, 8'd0);
		queue_pixel(CMD_CMY2HSV, 15'd0, 8'd255, 8'd128);
		queue_pixel(CMD_HSV2CMY, 15'd11520, 8'd200, 8'd100);
		queue_pixel(CMD_HSV2CMY, 15'd30000, 8'd255, 8'd255);
		queue_pixel(3'd5, 15'h7fff, 8'hff, 8'hff);
		queue_pixel(3'd6, 15'd1234, 8'd1, 8'd2);
		queue_pixel(3'd7, 15'h7fff, 8'hff, 8'hff);
		repeat (900) begin
			sel = $urandom_range(0, 99);
			if (sel < 8)
				queue_pixel(3'($urandom), 15'($urandom), 8'($urandom), 8'($urandom));
			else if (sel < 20)
				queue_pixel(3'($urandom_range(0, 4)), 15'($urandom),
					8'($urandom), 8'($urandom));
			else if (sel < 55)
				queue_pixel(3'(($urandom_range(0, 1) == 0) ? CMD_HSV2RGB : CMD_HSV2CMY),
					15'($urandom_range(0, 23039)), 8'($urandom), 8'($urandom));
			else
				queue_pixel(3'($urandom_range(0, 1) ? CMD_RGB2HSV :
					($urandom_range(0, 1) ? CMD_SWAP : CMD_CMY2HSV)),
					15'($urandom_range(0, 255)), 8'($urandom), 8'($urandom));
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_pixels.size() == 0 && !pixel_valid);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule

>>> files.f
+incdir+sv
sv/csc_pkg.sv
sv/color_space_converter.sv
dv/testbench.sv
